@@ rtl/cfd_pkg.sv @@
// cfd_pkg: shared types and constants of the capacity fill density block
// used by every rtl file of the block but cfd_ram, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int DIST_BITS_DEF  = 32;

    localparam int POINT_W    = 6;
    localparam int DIST_W     = 32;
    localparam int DEMAND_W   = 16;
    localparam int NPOINTS_W  = 7;
    localparam int CAP_W      = 16;
    localparam int DENSITY_W  = 32;
    localparam int FCOUNT_W   = 7;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_N_POINTS = 2'd0,
        CFG_CAPACITY = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_INIT  = 16'h0002,
        S_JA    = 16'h0004,
        S_JB    = 16'h0008,
        S_JC    = 16'h0010,
        S_KA    = 16'h0020,
        S_KB    = 16'h0040,
        S_KC    = 16'h0080,
        S_FA    = 16'h0100,
        S_FB    = 16'h0200,
        S_STORE = 16'h0400,
        S_OA    = 16'h0800,
        S_OB    = 16'h1000,
        S_OC    = 16'h2000,
        S_OD    = 16'h4000,
        S_OUT   = 16'h8000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/cfd_ram.sv @@
// cfd_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/cfd_div.sv @@
// cfd_div: restoring divider, one quotient bit per cycle
// depends on cfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfd_div
    import cfd_pkg::*;
#(
    parameter int NUMW = 67,
    parameter int DENW = 51
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [NUMW-1:0] num,
    input  wire logic [DENW-1:0] den,
    output logic      [NUMW-1:0] quot,
    output div_stat_t            stat
);

    localparam int CNTW = $clog2(NUMW + 1);

    logic [NUMW-1:0] q_reg, q_next;
    logic [DENW-1:0] rem_reg, rem_next;
    logic [DENW-1:0] den_reg, den_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DENW:0]   rem_sh;
    logic            ge;

    assign rem_sh = {rem_reg, q_reg[NUMW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNTW'(NUMW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DENW'(rem_sh - {1'b0, den_reg}) : rem_sh[DENW-1:0];
            q_next   = {q_reg[NUMW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot      = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

@@ rtl/capacity_fill_density.sv @@
// capacity_fill_density: top level, sequencer over the stores, sort, fill and density
// depends on cfd_pkg, cfd_ram, cfd_div
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata, tlast = last_entry
// m_axis    out  m_axis_tvalid/tready       tdata, tlast = last_result
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// a matrix entry without last is written into the stores and the block stays idle
// after last, per point i: an init pass over the n scratch entries, then per position j
// a selection pass over the remaining points and a fill step, then a store step; the sort
// reads the distance ram through its single read port; then per result the sums are read,
// one divider bit per cycle (none when the point's distance sum is zero), output may stall
// no clearing pass after reset; s_axis_tready is low from last entry until last result
`timescale 1ns / 1ps
`default_nettype none

module capacity_fill_density
    import cfd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // from_point[5:0], to_point[11:6], distance[43:12], demand[59:44], zero fill
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // point[5:0], density[37:6], fill_count[44:38], zero fill
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SUMW = DIST_BITS + CW;
    localparam int TDW  = DIST_BITS + 2 * CW;
    localparam int TCW  = 2 * CW;
    localparam int NUMW = TDW + CW + 16;
    localparam int DENW = SUMW + TCW;
    localparam int QXW  = (NUMW > 32) ? NUMW : 32;

    state_t state_reg, state_next;

    logic [NPOINTS_W-1:0] npts_reg, npts_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [PW-1:0]        cur_pt_reg, cur_pt_next;
    logic [DIST_BITS-1:0] cur_dist_reg, cur_dist_next;
    logic [PW-1:0]        kpt_reg, kpt_next;
    logic [CAP_W-1:0]     left_reg, left_next;
    logic [SUMW-1:0]      sum_reg, sum_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [TDW-1:0]       tdist_reg, tdist_next;
    logic [TCW-1:0]       tcnt_reg, tcnt_next;
    logic [NUMW-1:0]      num_reg, num_next;
    logic [DENW-1:0]      den_reg, den_next;
    logic                 zero_reg, zero_next;
    logic [CW-1:0]        cnt_o_reg, cnt_o_next;
    logic [DENSITY_W-1:0] dens_reg, dens_next;

    logic [POINT_W-1:0]   in_from, in_to;
    logic [DIST_W-1:0]    in_dist;
    logic [DEMAND_W-1:0]  in_dem;
    logic                 in_acc, in_ok;
    logic [CW-1:0]        n_eff;

    logic                 scr_we;
    logic [PW-1:0]        scr_waddr, scr_wdata, scr_raddr, scr_rd;
    logic [DIST_BITS-1:0] dist_rd;
    logic [DEMAND_W-1:0]  dem_rd;
    logic                 res_we;
    logic [SUMW-1:0]      sum_rd;
    logic [CW-1:0]        cnt_rd;
    logic [TDW+CW-1:0]    nprod;
    logic [DENW-1:0]      dprod;

    logic                 div_start;
    logic [NUMW-1:0]      quot;
    div_stat_t            div_stat;
    logic [QXW-1:0]       qx;

    assign in_from = s_axis_tdata[5:0];
    assign in_to   = s_axis_tdata[11:6];
    assign in_dist = s_axis_tdata[43:12];
    assign in_dem  = s_axis_tdata[59:44];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_ok         = in_acc && (32'(in_from) < MAX_POINTS) && (32'(in_to) < MAX_POINTS);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        if (npts_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(npts_reg) > MAX_POINTS)
        begin
            n_eff = CW'(MAX_POINTS);
        end
        else
        begin
            n_eff = CW'(npts_reg);
        end
    end

    // stores
    cfd_ram #(.WIDTH(DIST_BITS), .DEPTH(1 << (2 * PW))) u_dist_ram (
        .clk     (clk),
        .wr_en   (in_ok),
        .wr_addr ({PW'(in_from), PW'(in_to)}),
        .wr_data (DIST_BITS'(in_dist)),
        .rd_addr ({scr_rd, i_reg[PW-1:0]}),
        .rd_data (dist_rd)
    );

    cfd_ram #(.WIDTH(DEMAND_W), .DEPTH(1 << PW)) u_dem_ram (
        .clk     (clk),
        .wr_en   (in_ok),
        .wr_addr (PW'(in_from)),
        .wr_data (in_dem),
        .rd_addr (cur_pt_reg),
        .rd_data (dem_rd)
    );

    cfd_ram #(.WIDTH(PW), .DEPTH(1 << PW)) u_scr_ram (
        .clk     (clk),
        .wr_en   (scr_we),
        .wr_addr (scr_waddr),
        .wr_data (scr_wdata),
        .rd_addr (scr_raddr),
        .rd_data (scr_rd)
    );

    cfd_ram #(.WIDTH(SUMW), .DEPTH(1 << PW)) u_sum_ram (
        .clk     (clk),
        .wr_en   (res_we),
        .wr_addr (i_reg[PW-1:0]),
        .wr_data (sum_reg),
        .rd_addr (i_reg[PW-1:0]),
        .rd_data (sum_rd)
    );

    cfd_ram #(.WIDTH(CW), .DEPTH(1 << PW)) u_cnt_ram (
        .clk     (clk),
        .wr_en   (res_we),
        .wr_addr (i_reg[PW-1:0]),
        .wr_data (cnt_reg),
        .rd_addr (i_reg[PW-1:0]),
        .rd_data (cnt_rd)
    );

    cfd_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .quot  (quot),
        .stat  (div_stat)
    );

    assign nprod = tdist_reg * cnt_rd;
    assign dprod = sum_rd * tcnt_reg;
    assign qx    = QXW'(quot);

    always_comb
    begin
        scr_we    = 1'b0;
        scr_waddr = j_reg[PW-1:0];
        scr_wdata = j_reg[PW-1:0];
        scr_raddr = j_reg[PW-1:0];
        res_we    = (state_reg == S_STORE);
        div_start = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                scr_we = 1'b1;
            end
            S_KA:
            begin
                scr_raddr = k_reg[PW-1:0];
            end
            S_KC:
            begin
                scr_waddr = k_reg[PW-1:0];
                scr_wdata = cur_pt_reg;
                scr_we    = (dist_rd < cur_dist_reg);
            end
            S_OC:
            begin
                div_start = !zero_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        npts_next     = npts_reg;
        cap_next      = cap_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        cur_pt_next   = cur_pt_reg;
        cur_dist_next = cur_dist_reg;
        kpt_next      = kpt_reg;
        left_next     = left_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        tdist_next    = tdist_reg;
        tcnt_next     = tcnt_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        zero_next     = zero_reg;
        cnt_o_next    = cnt_o_reg;
        dens_next     = dens_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_N_POINTS: npts_next = cfg_data[NPOINTS_W-1:0];
                CFG_CAPACITY: cap_next  = cfg_data[CAP_W-1:0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    n_next     = n_eff;
                    i_next     = '0;
                    j_next     = '0;
                    left_next  = cap_reg;
                    sum_next   = '0;
                    cnt_next   = '0;
                    tdist_next = '0;
                    tcnt_next  = '0;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if ((j_reg + CW'(1)) == n_reg)
                begin
                    j_next     = '0;
                    state_next = S_JA;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            S_JA:
            begin
                state_next = S_JB;
            end
            S_JB:
            begin
                cur_pt_next = scr_rd;
                state_next  = S_JC;
            end
            S_JC:
            begin
                cur_dist_next = dist_rd;
                k_next        = j_reg + CW'(1);
                state_next    = ((j_reg + CW'(1)) == n_reg) ? S_FA : S_KA;
            end
            S_KA:
            begin
                state_next = S_KB;
            end
            S_KB:
            begin
                kpt_next   = scr_rd;
                state_next = S_KC;
            end
            S_KC:
            begin
                // strictly closer point moves into position j
                if (dist_rd < cur_dist_reg)
                begin
                    cur_pt_next   = kpt_reg;
                    cur_dist_next = dist_rd;
                end
                k_next     = k_reg + CW'(1);
                state_next = ((k_reg + CW'(1)) == n_reg) ? S_FA : S_KA;
            end
            S_FA:
            begin
                state_next = S_FB;
            end
            S_FB:
            begin
                if (dem_rd <= left_reg)
                begin
                    sum_next  = sum_reg + SUMW'(cur_dist_reg);
                    left_next = left_reg - dem_rd;
                    cnt_next  = cnt_reg + CW'(1);
                end
                j_next     = j_reg + CW'(1);
                state_next = ((j_reg + CW'(1)) == n_reg) ? S_STORE : S_JA;
            end
            S_STORE:
            begin
                tdist_next = tdist_reg + TDW'(sum_reg);
                tcnt_next  = tcnt_reg + TCW'(cnt_reg);
                left_next  = cap_reg;
                sum_next   = '0;
                cnt_next   = '0;
                j_next     = '0;
                if ((i_reg + CW'(1)) == n_reg)
                begin
                    i_next     = '0;
                    state_next = S_OA;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_INIT;
                end
            end
            S_OA:
            begin
                state_next = S_OB;
            end
            S_OB:
            begin
                zero_next  = (sum_rd == '0);
                num_next   = {nprod, 16'b0};
                den_next   = dprod;
                cnt_o_next = cnt_rd;
                state_next = S_OC;
            end
            S_OC:
            begin
                if (zero_reg)
                begin
                    dens_next  = '1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_OD;
                end
            end
            S_OD:
            begin
                if (div_stat.done)
                begin
                    dens_next  = ((qx >> 32) != '0) ? '1 : qx[DENSITY_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    if ((i_reg + CW'(1)) == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_OA;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            npts_reg  <= NPOINTS_W'(64);
            cap_reg   <= '0;
            n_reg     <= CW'(1);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            npts_reg  <= npts_next;
            cap_reg   <= cap_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_pt_reg   <= cur_pt_next;
        cur_dist_reg <= cur_dist_next;
        kpt_reg      <= kpt_next;
        left_reg     <= left_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        tdist_reg    <= tdist_next;
        tcnt_reg     <= tcnt_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        zero_reg     <= zero_next;
        cnt_o_reg    <= cnt_o_next;
        dens_reg     <= dens_next;
    end

    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tlast  = ((i_reg + CW'(1)) == n_reg);
    assign m_axis_tdata  = {3'b0, FCOUNT_W'(cnt_o_reg), dens_reg, POINT_W'(i_reg)};

endmodule

`default_nettype wire

@@ rtl/cfd_checker.sv @@
// cfd_checker: port level assertions for capacity_fill_density, bound to the top level
// depends on cfd_pkg and capacity_fill_density
`timescale 1ns / 1ps
`default_nettype none

module cfd_checker
    import cfd_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  s_axis_tlast,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tlast
);

    // no new input while results are pending
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // an entry without last gives no result
    a_no_result_on_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> !m_axis_tvalid)
        else $error("result after plain entry");

    // the last result closes the run
    a_end_of_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
        else $error("result after last result");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind capacity_fill_density cfd_checker u_cfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ tb/sv/tb_capacity_fill_density.sv @@
// tb_capacity_fill_density: self-checking testbench of capacity_fill_density
// loads random distance matrices over s_axis, checks every density result on m_axis
// depends on cfd_pkg and the rtl of capacity_fill_density
`timescale 1ns / 1ps

typedef struct {
    logic [5:0]  point;
    logic [31:0] density;
    logic [6:0]  fill_count;
    logic        last_result;
} density_result_t;

class density_scoreboard;
    logic [31:0] dist_mem [4096];
    logic [15:0] dem_mem [64];
    logic [6:0]  n_reg;
    logic [15:0] cap_reg;
    density_result_t expected_q [$];

    function new();
        n_reg   = 7'd64;
        cap_reg = 16'd0;
    endfunction

    function void set_config(cfd_pkg::cfg_index_t idx, logic [15:0] data);
        if (idx == cfd_pkg::CFG_N_POINTS) n_reg = data[6:0];
        else if (idx == cfd_pkg::CFG_CAPACITY) cap_reg = data;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_entry(logic [5:0] f, logic [5:0] t, logic [31:0] d,
                             logic [15:0] dm, logic last);
        int n;
        int cnt [64];
        logic [63:0] sum [64];
        int ord [64];
        int tmp;
        int total_cnt;
        logic [63:0] total_dist;
        logic [31:0] left;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        density_result_t r;
        dist_mem[f * 64 + t] = d;
        dem_mem[f] = dm;
        if (!last) return;
        n = n_reg;
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        total_cnt = 0;
        total_dist = 0;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++) ord[j] = j;
            for (int j = 0; j + 1 < n; j++)
                for (int k = j + 1; k < n; k++)
                    if (dist_mem[ord[k] * 64 + i] < dist_mem[ord[j] * 64 + i])
                    begin
                        tmp = ord[k];
                        ord[k] = ord[j];
                        ord[j] = tmp;
                    end
            left = cap_reg;
            sum[i] = 0;
            cnt[i] = 0;
            for (int j = 0; j < n; j++)
                if (dem_mem[ord[j]] <= left)
                begin
                    sum[i] += dist_mem[ord[j] * 64 + i];
                    left -= dem_mem[ord[j]];
                    cnt[i]++;
                end
            total_cnt += cnt[i];
            total_dist += sum[i];
        end
        for (int i = 0; i < n; i++)
        begin
            r.point = i[5:0];
            r.fill_count = cnt[i][6:0];
            r.last_result = (i + 1 == n);
            if (sum[i] == 0 || total_cnt == 0)
                r.density = 32'hFFFF_FFFF;
            else
            begin
                num = 128'(total_dist) * 128'(cnt[i]) * 128'd65536;
                den = 128'(sum[i]) * 128'(total_cnt);
                q = num / den;
                r.density = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
            expected_q.push_back(r);
        end
    endfunction

    function int check_result(logic [47:0] td, logic tl);
        density_result_t e;
        int errs;
        errs = 0;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result transaction, tdata %h", td);
            return 1;
        end
        e = expected_q.pop_front();
        if (td[5:0] !== e.point)
        begin
            $error("point: expected %0d actual %0d", e.point, td[5:0]);
            errs++;
        end
        if (td[37:6] !== e.density)
        begin
            $error("density: expected %h actual %h", e.density, td[37:6]);
            errs++;
        end
        if (td[44:38] !== e.fill_count)
        begin
            $error("fill_count: expected %0d actual %0d", e.fill_count, td[44:38]);
            errs++;
        end
        if (tl !== e.last_result)
        begin
            $error("last_result: expected %0d actual %0d", e.last_result, tl);
            errs++;
        end
        return errs;
    endfunction
endclass

module tb_capacity_fill_density;
    import cfd_pkg::*;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    density_scoreboard sb;
    int fails;
    int send_idle;
    int recv_stall;
    int hold_cycles;
    int items;
    int n_eff;
    logic [15:0] cap_now;
    bit wr_dist [64][64];

    capacity_fill_density u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver side, long hold-off counted here
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready = 0;
                hold_cycles--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            fails += sb.check_result(m_axis_tdata, m_axis_tlast);

    function automatic logic [31:0] pick_distance();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom_range(3, 1);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_demand();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(3000));
        endcase
    endfunction

    task automatic send_entry(logic [5:0] f, logic [5:0] t, logic last);
        logic [31:0] d;
        logic [15:0] dm;
        d = pick_distance();
        dm = pick_demand();
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid = 0;
            @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {4'b0, dm, d, t, f};
        s_axis_tlast = last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_entry(f, t, d, dm, last);
        wr_dist[f][t] = 1;
        items++;
        @(negedge clk);
        s_axis_tvalid = 0;
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [15:0] data);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_config(idx, data);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending() > 0) @(posedge clk);
        repeat (30) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_points(logic [15:0] data);
        cfg_write(CFG_N_POINTS, data);
        n_eff = data[6:0];
        if (n_eff < 1) n_eff = 1;
        if (n_eff > 64) n_eff = 64;
    endtask

    // one matrix load ending in last, noise entries first
    task automatic run_frame(int noise);
        repeat (noise) send_entry(6'($urandom), 6'($urandom), 1'b0);
        for (int p = 0; p < n_eff; p++)
            for (int i = 0; i < n_eff; i++)
                if (!wr_dist[p][i] || $urandom_range(2) == 0)
                    send_entry(6'(p), 6'(i), 1'b0);
        send_entry(6'($urandom_range(n_eff - 1)), 6'($urandom_range(n_eff - 1)), 1'b1);
        // keep offering while the receiver holds off, so the input stalls
        if (hold_cycles > 0)
            send_entry(6'($urandom), 6'($urandom), 1'b0);
        drain();
    endtask

    initial
    begin
        sb = new();
        fails = 0;
        items = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_cycles = 0;
        n_eff = 64;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        cfg_valid = 0;
        cfg_index = CFG_N_POINTS;
        cfg_data = '0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (3) @(negedge clk);

        // directed: n of zero, single point, capacity extremes
        set_points(16'h0000);
        cfg_write(CFG_CAPACITY, 16'h0000);
        run_frame(2);
        set_points(16'hFF81);
        cfg_write(CFG_CAPACITY, 16'hFFFF);
        run_frame(0);
        set_points(16'd2);
        run_frame(1);
        set_points(16'd3);
        cfg_write(CFG_CAPACITY, 16'd0);
        run_frame(0);

        // random frames over the idling phases
        for (int fr = 0; items < 300; fr++)
        begin
            case (fr % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 69; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 69; end
                default: begin send_idle = 21; recv_stall = 21; end
            endcase
            set_points({9'($urandom_range(511)), 7'(2 + $urandom_range(4))});
            case ($urandom_range(3))
                0: cap_now = 16'd0;
                1: cap_now = 16'hFFFF;
                default: cap_now = 16'($urandom_range(9000));
            endcase
            cfg_write(CFG_CAPACITY, cap_now);
            if (fr == 5) hold_cycles = 3000;
            run_frame($urandom_range(4));
        end

        fails += sb.pending();
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
